// ===== src/akf_pkg.sv =====
// akf_pkg: shared types and constants of the angle / gyro-bias Kalman filter.
// Used by akf_ctrl, akf_datapath and the top level; depends on nothing.
package akf_pkg;

  // Default arithmetic format
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned DT_W       = 20;
  localparam int unsigned QN_W       = 27;
  localparam int unsigned WN_W       = 27;

  localparam logic [DT_W-1:0] DT_RST = 20'd6554;
  localparam logic [QN_W-1:0] QN_RST = 27'd6554;
  localparam logic [WN_W-1:0] WN_RST = 27'd262144;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME    = 2'd0,
    CFG_PROC_NOISE   = 2'd1,
    CFG_MEAS_NOISE   = 2'd2
  } cfg_idx_e;

  // Gyro scaling: 250 / 32768 deg/s per count
  localparam logic [7:0] GYRO_SCALE = 8'd250;
  localparam int unsigned GYRO_SHIFT = 15;

  // Operation codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] gyro_raw;
    logic signed [23:0] measured_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate;
    logic signed [31:0] bias_estimate;
  } out_item_t;

  // Datapath program: one multiply or divide per step, then a writeback
  typedef enum logic [3:0] {
    ST_XB, ST_XU, ST_A00, ST_A01, ST_P00, ST_P10, ST_K0, ST_K1,
    ST_ANG, ST_BIA, ST_KS0, ST_KS1, ST_C0, ST_C1, ST_C2, ST_C3
  } step_e;

  typedef struct packed {
    logic  load;      // input transfer this cycle
    logic  go;        // start the unit of the current step
    logic  wb;        // write back the unit result
    logic  out_load;  // move the state into the output register
    step_e step;
  } dp_cmd_t;

  typedef struct packed {
    logic done;       // unit finished, result valid
  } dp_stat_t;

endpackage

// ===== src/akf_ctrl.sv =====
// akf_ctrl: sequencer of the Kalman filter; steps the datapath program.
// Depends on akf_pkg (command/status structs, step codes).
module akf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output akf_pkg::dp_cmd_t   cmd_o,
  input  akf_pkg::dp_stat_t  stat_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_WB, S_FIN
  } state_e;

  state_e                 state_q;
  akf_pkg::step_e         step_q;
  logic                   out_valid_q;
  logic                   accept;
  logic                   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o.load     = accept;
    cmd_o.go       = (state_q == S_ISSUE);
    cmd_o.wb       = (state_q == S_WB);
    cmd_o.out_load = (state_q == S_FIN) && slot_free;
    cmd_o.step     = step_q;
  end

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= akf_pkg::ST_XB;
      out_valid_q <= 1'b0;
    end else begin
      // result register: filled from FIN, emptied by an output transfer
      if (state_q == S_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            step_q  <= akf_pkg::ST_XB;
            state_q <= (in_op_i == akf_pkg::OP_START) ? S_FIN : S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (stat_i.done) state_q <= S_WB;
        end
        S_WB: begin
          if (step_q == akf_pkg::ST_C3) begin
            state_q <= S_FIN;
          end else begin
            step_q  <= akf_pkg::step_e'(step_q + 4'd1);
            state_q <= S_ISSUE;
          end
        end
        S_FIN: begin
          if (slot_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.done |-> (state_q == S_WAIT))
    else $error("unit done outside of wait state");
  a_wb_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> $past(stat_i.done))
    else $error("writeback without unit result");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready held after transfer");
`endif

endmodule

// ===== src/akf_datapath.sv =====
// akf_datapath: filter state, config registers, sequential multiplier
// (8 bits per cycle) and restoring divider (1 bit per cycle). Uses akf_pkg.
module akf_datapath #(
  parameter int unsigned DATA_WIDTH = akf_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [akf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [akf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  akf_pkg::in_item_t               in_item_i,
  output akf_pkg::out_item_t              out_item_o,
  input  akf_pkg::dp_cmd_t                cmd_i,
  output akf_pkg::dp_stat_t               stat_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned MW   = 2 * DW + 1;
  localparam int unsigned SW   = DW + 3;
  localparam int unsigned QW   = DW + FB;
  localparam int unsigned NDIG = (DW + 7) / 8;
  localparam int unsigned MCW  = $clog2(NDIG + 1);
  localparam int unsigned DCW  = $clog2(QW + 1);
  localparam logic [DW-1:0] ONE  = DW'(1) << FB;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  // ---------------------------------------------------------------- helpers
  function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

  // apply sign to a magnitude, saturating to DW bits
  function automatic logic [DW-1:0] ssat(input logic [MW-1:0] m, input logic neg);
    logic [MW-1:0] lim;
    logic [MW-1:0] mm;
    logic [DW-1:0] r;
    lim = neg ? (MW'(1) << (DW - 1)) : ((MW'(1) << (DW - 1)) - MW'(1));
    mm  = (m > lim) ? lim : m;
    r   = mm[DW-1:0];
    return neg ? (~r + DW'(1)) : r;
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic [DW-1:0] v);
    return $signed({{3{v[DW-1]}}, v});
  endfunction

  function automatic logic [DW-1:0] sat_sum(input logic signed [SW-1:0] v);
    logic [SW-DW:0] hi;
    hi = v[SW-1:DW-1];
    if (hi == '0 || hi == '1) return v[DW-1:0];
    return v[SW-1] ? VMIN : VMAX;
  endfunction

  // Q16.16 magnitude to internal format, rounded, saturated
  function automatic logic [DW-1:0] from_q16(input logic [26:0] m, input logic neg);
    logic [27+FB-1:0] w;
    logic [MW-1:0]    r;
    w = (27 + FB)'(m) << FB;
    r = MW'(w >> 16) + MW'(w[15]);
    return ssat(r, neg);
  endfunction

  // internal format to Q16.16, saturated to 32 bits
  function automatic logic [31:0] to_q16(input logic [DW-1:0] v);
    logic [DW+15:0] w;
    logic [DW+16:0] r;
    logic [DW+16:0] lim;
    logic [DW+16:0] mm;
    w   = (DW + 16)'(mag(v)) << 16;
    r   = (DW + 17)'(w >> FB) + (DW + 17)'(w[FB-1]);
    lim = v[DW-1] ? (DW + 17)'(33'h080000000) : (DW + 17)'(33'h07fffffff);
    mm  = (r > lim) ? lim : r;
    return v[DW-1] ? (~mm[31:0] + 32'd1) : mm[31:0];
  endfunction

  // ------------------------------------------------------------- registers
  logic [akf_pkg::DT_W-1:0] dt_cfg_q;
  logic [akf_pkg::QN_W-1:0] qn_cfg_q;
  logic [akf_pkg::WN_W-1:0] wn_cfg_q;

  logic [DW-1:0] ang_q, bia_q, c0_q, c1_q, c2_q, c3_q;
  logic [DW-1:0] y_q, u_q, xp0_q, ap00_q, ap01_q, p00_q, p10_q, p11_q;
  logic [DW-1:0] eps_q, s_q, k0_q, k1_q, ks0_q, ks1_q;
  logic signed [SW-1:0] t_q;
  akf_pkg::out_item_t out_q;

  // multiplier
  logic [2*DW-1:0] mx_q, macc_q;
  logic [DW-1:0]   mb_q;
  logic            mneg_q, mbusy_q, mdone_q;
  logic [MCW-1:0]  mcnt_q;
  // divider
  logic [QW-1:0]   dn_q, dq_q;
  logic [DW-1:0]   dd_q;
  logic [DW:0]     drem_q;
  logic            dneg_q, dbusy_q, ddone_q;
  logic [DCW-1:0]  dcnt_q;

  // ------------------------------------------------------- derived values
  logic [DW-1:0] dt, qn, wn, y_in, u_in;
  logic [23:0]   y_mag;
  logic [15:0]   g_mag;
  logic [23:0]   g_prod;
  logic [24+FB-1:0] g_w;
  logic          is_div;
  logic [DW-1:0] op_a, op_b;

  assign dt = from_q16(27'(dt_cfg_q), 1'b0);
  assign qn = from_q16(qn_cfg_q, 1'b0);
  assign wn = from_q16(wn_cfg_q, 1'b0);

  assign y_mag  = in_item_i.measured_angle[23] ? (~in_item_i.measured_angle + 24'd1)
                                               : in_item_i.measured_angle;
  assign y_in   = from_q16(27'(y_mag), in_item_i.measured_angle[23]);
  assign g_mag  = in_item_i.gyro_raw[15] ? (~in_item_i.gyro_raw + 16'd1)
                                         : in_item_i.gyro_raw;
  assign g_prod = 24'(g_mag) * 24'(akf_pkg::GYRO_SCALE);
  assign g_w    = (24 + FB)'(g_prod) << FB;
  assign u_in   = ssat(MW'(g_w >> akf_pkg::GYRO_SHIFT) + MW'(g_w[akf_pkg::GYRO_SHIFT-1]),
                       in_item_i.gyro_raw[15]);

  assign is_div = (cmd_i.step == akf_pkg::ST_K0) || (cmd_i.step == akf_pkg::ST_K1);

  // Operand select per step
  always_comb begin
    op_a = dt;
    op_b = bia_q;
    case (cmd_i.step)
      akf_pkg::ST_XB:  begin op_a = dt;    op_b = bia_q;  end
      akf_pkg::ST_XU:  begin op_a = dt;    op_b = u_q;    end
      akf_pkg::ST_A00: begin op_a = dt;    op_b = c2_q;   end
      akf_pkg::ST_A01: begin op_a = dt;    op_b = c3_q;   end
      akf_pkg::ST_P00: begin op_a = dt;    op_b = ap01_q; end
      akf_pkg::ST_P10: begin op_a = dt;    op_b = c3_q;   end
      akf_pkg::ST_K0:  begin op_a = p00_q; op_b = s_q;    end
      akf_pkg::ST_K1:  begin op_a = p10_q; op_b = s_q;    end
      akf_pkg::ST_ANG: begin op_a = k0_q;  op_b = eps_q;  end
      akf_pkg::ST_BIA: begin op_a = k1_q;  op_b = eps_q;  end
      akf_pkg::ST_KS0: begin op_a = k0_q;  op_b = s_q;    end
      akf_pkg::ST_KS1: begin op_a = k1_q;  op_b = s_q;    end
      akf_pkg::ST_C0:  begin op_a = ks0_q; op_b = k0_q;   end
      akf_pkg::ST_C1:  begin op_a = ks0_q; op_b = k1_q;   end
      akf_pkg::ST_C2:  begin op_a = ks1_q; op_b = k0_q;   end
      akf_pkg::ST_C3:  begin op_a = ks1_q; op_b = k1_q;   end
      default: ;
    endcase
  end

  // Unit results: rounding and saturation
  logic [DW:0]   dt_try;
  logic          dge;
  logic          dround;
  logic [DW-1:0] mul_res, div_res, res, p00_pre;
  logic          s_pos;

  assign dt_try  = {drem_q[DW-1:0], dn_q[QW-1]};
  assign dge     = (dt_try >= {1'b0, dd_q});
  assign dround  = (drem_q >= ({1'b0, dd_q} - drem_q));
  assign mul_res = ssat((MW'(macc_q) + (MW'(1) << (FB - 1))) >> FB, mneg_q);
  assign div_res = ssat(MW'(dq_q) + MW'(dround), dneg_q);
  assign res     = is_div ? div_res : mul_res;
  assign p00_pre = sat_sum(sx(ap00_q) - sx(res));
  assign s_pos   = !s_q[DW-1] && (s_q != '0);

  assign stat_o.done = mdone_q || ddone_q;
  assign out_item_o  = out_q;

  // Control state, config and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_cfg_q <= akf_pkg::DT_RST;
      qn_cfg_q <= akf_pkg::QN_RST;
      wn_cfg_q <= akf_pkg::WN_RST;
      ang_q    <= '0;
      bia_q    <= '0;
      c0_q     <= ONE;
      c1_q     <= '0;
      c2_q     <= '0;
      c3_q     <= ONE;
      mbusy_q  <= 1'b0;
      mdone_q  <= 1'b0;
      mcnt_q   <= '0;
      dbusy_q  <= 1'b0;
      ddone_q  <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      // config writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          akf_pkg::CFG_STEP_TIME:  dt_cfg_q <= cfg_data_i[akf_pkg::DT_W-1:0];
          akf_pkg::CFG_PROC_NOISE: qn_cfg_q <= cfg_data_i;
          akf_pkg::CFG_MEAS_NOISE: wn_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      // start operation
      if (cmd_i.load && in_item_i.operation == akf_pkg::OP_START) begin
        ang_q <= y_in;
        bia_q <= '0;
        c0_q  <= ONE;
        c1_q  <= '0;
        c2_q  <= '0;
        c3_q  <= ONE;
      end
      // multiplier sequencing; done pulses after the last digit
      mdone_q <= mbusy_q && !(cmd_i.go && !is_div) && (mcnt_q == MCW'(NDIG - 1));
      if (cmd_i.go && !is_div) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + MCW'(1);
        if (mcnt_q == MCW'(NDIG - 1)) mbusy_q <= 1'b0;
      end
      // divider sequencing; done pulses after the last quotient bit
      ddone_q <= dbusy_q && !(cmd_i.go && is_div) && (dcnt_q == DCW'(QW - 1));
      if (cmd_i.go && is_div) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(QW - 1)) dbusy_q <= 1'b0;
      end
      // state writeback
      if (cmd_i.wb) begin
        case (cmd_i.step)
          akf_pkg::ST_ANG: ang_q <= sat_sum(sx(xp0_q) + sx(res));
          akf_pkg::ST_BIA: bia_q <= sat_sum(sx(bia_q) + sx(res));
          akf_pkg::ST_C0:  c0_q  <= sat_sum(sx(p00_q) - sx(res));
          akf_pkg::ST_C1:  c1_q  <= sat_sum(sx(ap01_q) - sx(res));
          akf_pkg::ST_C2:  c2_q  <= sat_sum(sx(p10_q) - sx(res));
          akf_pkg::ST_C3:  c3_q  <= sat_sum(sx(p11_q) - sx(res));
          default: ;
        endcase
      end
    end
  end

  // Unit data and intermediate values
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      y_q <= y_in;
      u_q <= u_in;
    end
    // multiplier: one 8-bit digit of the second operand per cycle
    if (cmd_i.go && !is_div) begin
      mx_q   <= (2 * DW)'(mag(op_a));
      mb_q   <= mag(op_b);
      macc_q <= '0;
      mneg_q <= op_a[DW-1] ^ op_b[DW-1];
    end else if (mbusy_q) begin
      macc_q <= macc_q + (2 * DW)'(mx_q * (2 * DW)'(mb_q[7:0]));
      mx_q   <= mx_q << 8;
      mb_q   <= mb_q >> 8;
    end
    // divider: restoring, one quotient bit per cycle
    if (cmd_i.go && is_div) begin
      dn_q   <= QW'(mag(op_a)) << FB;
      dd_q   <= op_b;
      drem_q <= '0;
      dq_q   <= '0;
      dneg_q <= op_a[DW-1];
    end else if (dbusy_q) begin
      drem_q <= dge ? (dt_try - {1'b0, dd_q}) : dt_try;
      dq_q   <= {dq_q[QW-2:0], dge};
      dn_q   <= dn_q << 1;
    end
    if (cmd_i.wb) begin
      case (cmd_i.step)
        akf_pkg::ST_XB:  t_q    <= sx(ang_q) - sx(res);
        akf_pkg::ST_XU:  xp0_q  <= sat_sum(t_q + sx(res));
        akf_pkg::ST_A00: ap00_q <= sat_sum(sx(c0_q) - sx(res));
        akf_pkg::ST_A01: ap01_q <= sat_sum(sx(c1_q) - sx(res));
        akf_pkg::ST_P00: p00_q  <= sat_sum(sx(p00_pre) + sx(qn));
        akf_pkg::ST_P10: begin
          p10_q <= sat_sum(sx(c2_q) - sx(res));
          p11_q <= sat_sum(sx(c3_q) + sx(qn));
          eps_q <= sat_sum(sx(y_q) - sx(xp0_q));
          s_q   <= sat_sum(sx(p00_q) + sx(wn));
        end
        akf_pkg::ST_K0:  k0_q  <= s_pos ? res : '0;
        akf_pkg::ST_K1:  k1_q  <= s_pos ? res : '0;
        akf_pkg::ST_KS0: ks0_q <= res;
        akf_pkg::ST_KS1: ks1_q <= res;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.angle_estimate <= $signed(to_q16(ang_q));
      out_q.bias_estimate  <= $signed(to_q16(bia_q));
    end
  end

endmodule

// ===== src/angle_gyro_bias_kalman_filter.sv =====
// Two-state (angle, gyro bias) Kalman filter: controller plus datapath.
// Depends on akf_pkg, akf_ctrl and akf_datapath.
//
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   step_time, process_noise or measurement_noise; always ready, write only
//   while no item is in flight.
//   Input channel (in_valid_i/in_ready_o, in_item_i): operation 0 restarts
//   the filter from the measured angle, operation 1 runs a full update.
//   Output channel (out_valid_o/out_ready_i, out_item_o): one angle/bias
//   estimate per input transfer, in Q16.16.
// Operation: an update runs 14 multiplies and two divides in sequence, each
//   followed by a writeback; a start skips the unit steps and goes straight
//   to the output register. The input is ready again as soon as the result
//   sits in the output register.
// Reset: registers return to their defaults, angle and bias to zero and the
//   covariance to identity. If the receiver stalls, the result is held and
//   the next item finishes its work and then waits for the register to free.
module angle_gyro_bias_kalman_filter #(
  parameter int unsigned DATA_WIDTH = akf_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [akf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [akf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  akf_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output akf_pkg::out_item_t              out_item_o
);

  akf_pkg::dp_cmd_t  cmd;
  akf_pkg::dp_stat_t stat;

  // config register file is always ready
  assign cfg_ready_o = 1'b1;

  akf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_item_i.operation),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  akf_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== dv/tb_angle_gyro_bias_kalman_filter.sv =====
// Self-checking testbench of angle_gyro_bias_kalman_filter: directed table, register extremes, then random items.
// A fixed-point filter predictor checks every result. Depends on akf_pkg and the top level.
module tb_angle_gyro_bias_kalman_filter;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam longint VMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int UPDATE_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 760;
  localparam int MAX_REPORTS = 10;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [akf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [akf_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  akf_pkg::in_item_t in_item;
  akf_pkg::out_item_t out_item;

  angle_gyro_bias_kalman_filter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item)
  );

  // Filter state kept by the predictor
  longint step_dt, proc_q, meas_w;
  longint angle_q, bias_q;
  longint cov[4];

  akf_pkg::out_item_t estimate_q[$];
  int mismatches;
  bit timed_out;
  bit stim_done;
  bit idle_on;
  int hold_off;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? longint'(VMAX) + 1 : longint'(VMAX);
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // Rounded (a*b) >> FB, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(mag(a)) * 128'(mag(b)) + (128'd1 << (FB - 1));
    p = p >> FB;
    if (p[127:64] != 0) return neg ? VMIN : VMAX;
    return apply_sign(p[63:0], neg);
  endfunction

  // Rounded (num << FB) / den for den > 0, saturated
  function automatic longint fx_div(longint num, longint den);
    logic [127:0] n, q, r;
    bit neg;
    neg = num < 0;
    n = 128'(mag(num)) << FB;
    q = n / 128'(den);
    r = n - q * 128'(den);
    if (q[127:62] != 0) return neg ? VMIN : VMAX;
    if (r >= 128'(den) - r) q = q + 1;
    return apply_sign(q[63:0], neg);
  endfunction

  function automatic logic [31:0] to_out(longint v);
    longint unsigned m, lim;
    lim = v < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
    m = mag(v);
    if (m > lim) m = lim;
    return v < 0 ? 32'(-longint'(m)) : 32'(m);
  endfunction

  task automatic filter_reset();
    step_dt = akf_pkg::DT_RST; proc_q = akf_pkg::QN_RST; meas_w = akf_pkg::WN_RST;
    angle_q = 0; bias_q = 0;
    cov = '{ONE, 0, 0, ONE};
  endtask

  // Predict the estimate caused by one input transfer
  task automatic filter_step(akf_pkg::in_item_t it);
    longint y, u, xp0, xp1, ap00, ap01, p00, p01, p10, p11, eps, s, k0, k1, ks0, ks1, num;
    akf_pkg::out_item_t r;
    y = longint'(it.measured_angle);
    if (it.operation == akf_pkg::OP_START) begin
      angle_q = y; bias_q = 0;
      cov = '{ONE, 0, 0, ONE};
    end else begin
      num = longint'(it.gyro_raw) * 250 * ONE;
      u = apply_sign((mag(num) >> 15) + ((mag(num) >> 14) & 1), num < 0);
      xp0 = sat(angle_q - fx_mul(step_dt, bias_q) + fx_mul(step_dt, u));
      xp1 = bias_q;
      ap00 = sat(cov[0] - fx_mul(step_dt, cov[2]));
      ap01 = sat(cov[1] - fx_mul(step_dt, cov[3]));
      p00 = sat(sat(ap00 - fx_mul(step_dt, ap01)) + proc_q);
      p01 = ap01;
      p10 = sat(cov[2] - fx_mul(step_dt, cov[3]));
      p11 = sat(cov[3] + proc_q);
      eps = sat(y - xp0);
      s = sat(p00 + meas_w);
      k0 = 0; k1 = 0;
      if (s > 0) begin
        k0 = fx_div(p00, s);
        k1 = fx_div(p10, s);
      end
      angle_q = sat(xp0 + fx_mul(k0, eps));
      bias_q = sat(xp1 + fx_mul(k1, eps));
      ks0 = fx_mul(k0, s);
      ks1 = fx_mul(k1, s);
      cov[0] = sat(p00 - fx_mul(ks0, k0));
      cov[1] = sat(p01 - fx_mul(ks0, k1));
      cov[2] = sat(p10 - fx_mul(ks1, k0));
      cov[3] = sat(p11 - fx_mul(ks1, k1));
    end
    r.angle_estimate = to_out(angle_q);
    r.bias_estimate = to_out(bias_q);
    estimate_q.push_back(r);
  endtask

  // Register write, only while idle; returns at the falling edge with valid still up
  task automatic write_reg(akf_pkg::cfg_idx_e idx, logic [akf_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      akf_pkg::CFG_STEP_TIME: step_dt = val[akf_pkg::DT_W-1:0];
      akf_pkg::CFG_PROC_NOISE: proc_q = val[akf_pkg::QN_W-1:0];
      default: meas_w = val[akf_pkg::WN_W-1:0];
    endcase
    @(negedge clk);
  endtask

  // Send one item; returns after its transfer, at the falling edge
  task automatic send_item(akf_pkg::in_item_t it);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    filter_step(it);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (estimate_q.size() != 0 && !timed_out) @(negedge clk);
    repeat (UPDATE_CYCLES) @(negedge clk);
  endtask

  function automatic akf_pkg::in_item_t rand_item(bit upd);
    akf_pkg::in_item_t it;
    it.operation = upd ? akf_pkg::OP_UPDATE : akf_pkg::OP_START;
    it.gyro_raw = 16'($urandom);
    case ($urandom_range(3))
      0: it.measured_angle = 24'($urandom_range(5898240 * 2) - 5898240);
      1: it.measured_angle = 24'($urandom_range(655360 * 2) - 655360);
      2: it.measured_angle = 24'($urandom);
      default: it.measured_angle = 24'($urandom_range(65536 * 20) - 65536 * 10);
    endcase
    return it;
  endfunction

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 19);
    end
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (estimate_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected result %h", out_item);
      end else begin
        if (out_item.angle_estimate !== estimate_q[0].angle_estimate ||
            out_item.bias_estimate !== estimate_q[0].bias_estimate) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: angle exp %h got %h, bias exp %h got %h",
                     estimate_q[0].angle_estimate, out_item.angle_estimate,
                     estimate_q[0].bias_estimate, out_item.bias_estimate);
        end
        void'(estimate_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
      timed_out = 1'b1;
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed rows: operation, gyro, angle, whether the estimate is read off directly
  typedef struct {
    logic op;
    logic signed [15:0] gyro;
    logic signed [23:0] ang;
    bit known;
  } row_t;

  row_t rows[] = '{
    '{akf_pkg::OP_START, 16'sd0, 24'sd0, 1'b1},
    '{akf_pkg::OP_START, 16'sd0, 24'sd5898240, 1'b1},
    '{akf_pkg::OP_START, 16'sd0, -24'sd5898240, 1'b1},
    '{akf_pkg::OP_UPDATE, 16'sh7FFF, 24'sd5898240, 1'b0},
    '{akf_pkg::OP_UPDATE, 16'sh8000, -24'sd5898240, 1'b0},
    '{akf_pkg::OP_UPDATE, 16'sd0, 24'sd0, 1'b0},
    '{akf_pkg::OP_UPDATE, -16'sd1, 24'sd65536, 1'b0},
    '{akf_pkg::OP_START, 16'sh8000, 24'sd65536, 1'b1},
    '{akf_pkg::OP_UPDATE, 16'sd1, 24'sd65536, 1'b0},
    '{akf_pkg::OP_UPDATE, 16'sh5555, 24'sh7FFFFF, 1'b0},
    '{akf_pkg::OP_UPDATE, 16'shAAAA, 24'sh800000, 1'b0},
    '{akf_pkg::OP_UPDATE, 16'sd100, -24'sd1, 1'b0}
  };

  initial begin
    akf_pkg::in_item_t it;
    int n;
    rst_n = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_item = '0;
    mismatches = 0; timed_out = 1'b0; stim_done = 1'b0;
    idle_on = 1'b1; hold_off = 0;
    filter_reset();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table
    foreach (rows[i]) begin
      it.operation = rows[i].op;
      it.gyro_raw = rows[i].gyro;
      it.measured_angle = rows[i].ang;
      send_item(it);
      if (rows[i].known) begin
        estimate_q[$].angle_estimate = 32'(longint'(rows[i].ang));
        estimate_q[$].bias_estimate = '0;
      end
    end
    drain();

    // Register extremes, random and default values, each followed by a start and a short update run
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'd1);
                 write_reg(akf_pkg::CFG_PROC_NOISE, 27'd0);
                 write_reg(akf_pkg::CFG_MEAS_NOISE, 27'd1); end
        1: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'd655360);
                 write_reg(akf_pkg::CFG_PROC_NOISE, 27'd67108864);
                 write_reg(akf_pkg::CFG_MEAS_NOISE, 27'd67108864); end
        2: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'hFFFFF);
                 write_reg(akf_pkg::CFG_PROC_NOISE, 27'h7FFFFFF);
                 write_reg(akf_pkg::CFG_MEAS_NOISE, 27'h7FFFFFF); end
        3: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'd655);
                 write_reg(akf_pkg::CFG_PROC_NOISE, 27'd65);
                 write_reg(akf_pkg::CFG_MEAS_NOISE, 27'd65536); end
        4: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'($urandom_range(655360, 1)));
                 write_reg(akf_pkg::CFG_PROC_NOISE, 27'($urandom_range(67108864)));
                 write_reg(akf_pkg::CFG_MEAS_NOISE, 27'($urandom_range(67108864, 1))); end
        default: begin write_reg(akf_pkg::CFG_STEP_TIME, 27'(akf_pkg::DT_RST));
                 write_reg(akf_pkg::CFG_PROC_NOISE, akf_pkg::QN_RST);
                 write_reg(akf_pkg::CFG_MEAS_NOISE, akf_pkg::WN_RST); end
      endcase
      cfg_valid <= 1'b0;
      send_item(rand_item(1'b0));
      repeat (12) send_item(rand_item(1'b1));
      drain();
    end

    // Random part: mostly update runs after a start; one quiet stretch, one long hold-off, one drain
    n = 0;
    while (n < RANDOM_ITEMS) begin
      idle_on = !(n >= 300 && n < 400);
      if (n == 500) hold_off = 2000;
      if (n == 650) begin
        in_valid <= 1'b0;
        while (estimate_q.size() != 0) @(negedge clk);
      end
      send_item(rand_item($urandom_range(99) >= 6));
      n++;
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;
    stim_done = 1'b1;

    // Wait for the rest, with a limit
    n = 0;
    while (estimate_q.size() != 0 && n < WATCHDOG_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (UPDATE_CYCLES) @(negedge clk);
    if (mismatches == 0 && estimate_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
